// File: rtl/core/lc3b_instruction_execute_macros.svh
// Assertion macros used by the checker of the LC-3b execute unit.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef LC3B_INSTRUCTION_EXECUTE_MACROS_SVH
`define LC3B_INSTRUCTION_EXECUTE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define LC3B_ASSERT_COND(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that, once seen, requires another one in the next cycle.
`define LC3B_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// File: rtl/core/lc3b_ex_pkg.sv
// Types, opcodes and helper functions for the LC-3b execute unit.
// No dependencies; every other file of the block but the macros header uses this package.
`default_nettype none

package lc3b_ex_pkg;

  localparam int REG_AW = 3;

  localparam logic [3:0] OP_BR   = 4'd0;
  localparam logic [3:0] OP_ADD  = 4'd1;
  localparam logic [3:0] OP_LDB  = 4'd2;
  localparam logic [3:0] OP_STB  = 4'd3;
  localparam logic [3:0] OP_JSR  = 4'd4;
  localparam logic [3:0] OP_AND  = 4'd5;
  localparam logic [3:0] OP_LDW  = 4'd6;
  localparam logic [3:0] OP_STW  = 4'd7;
  localparam logic [3:0] OP_RTI  = 4'd8;
  localparam logic [3:0] OP_XOR  = 4'd9;
  localparam logic [3:0] OP_JMP  = 4'd12;
  localparam logic [3:0] OP_SHF  = 4'd13;
  localparam logic [3:0] OP_LEA  = 4'd14;
  localparam logic [3:0] OP_TRAP = 4'd15;

  localparam logic [REG_AW-1:0] LINK_REG = 3'd7;

  // Flags are kept as {N, Z, P}.
  localparam logic [2:0] FLAGS_RESET = 3'b010;

  typedef enum logic [1:0] {
    ST_EXECUTED = 2'd0,
    ST_UNIMPL   = 2'd1,
    ST_UNKNOWN  = 2'd2
  } status_t;

  typedef struct packed {
    logic [15:0] instruction;
    logic [15:0] trap_target;
  } in_t;

  typedef struct packed {
    logic [15:0]       next_pc;
    logic              dest_written;
    logic [REG_AW-1:0] dest_reg;
    logic [15:0]       dest_value;
    logic              flag_n;
    logic              flag_z;
    logic              flag_p;
    status_t           status;
    logic              halted;
  } out_t;

  typedef struct packed {
    logic              en;
    logic [REG_AW-1:0] addr;
    logic [15:0]       data;
  } rf_wr_t;

  function automatic logic [2:0] nzp_of(input logic [15:0] v);
    logic [2:0] f;
    if (v == 16'h0000) begin
      f = 3'b010;
    end else if (v[15]) begin
      f = 3'b100;
    end else begin
      f = 3'b001;
    end
    return f;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/lc3b_instruction_execute.sv
// LC-3b execute unit. A taken input passes the execute stage, then the output register.
// Throughput: one instruction per cycle unless the output stalls, set by the single execute
// stage that reads the register file memory on the accept edge and writes it back on advance.
// Reset: PC 0, flags Z, registers read as zero through per-entry valid bits (no clear sweep).
// A configuration write, taken only while the execute stage is empty, loads the PC.
`default_nettype none

module lc3b_instruction_execute #(
  parameter int REG_COUNT = 8
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire lc3b_ex_pkg::in_t  in_data,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output lc3b_ex_pkg::out_t      out_data,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [15:0]       cfg_data
);

  logic              s1_valid;
  lc3b_ex_pkg::in_t  s1_item;
  logic              s1_adv;
  logic              in_accept;
  logic [15:0]       pc;
  logic [2:0]        flags;
  logic [15:0]       sr1_value;
  logic [15:0]       sr2_value;
  lc3b_ex_pkg::out_t exec;
  lc3b_ex_pkg::rf_wr_t rf_wr;

  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign in_accept = in_valid && in_ready;
  assign cfg_ready = !s1_valid;

  assign rf_wr.en   = s1_adv && exec.dest_written;
  assign rf_wr.addr = exec.dest_reg;
  assign rf_wr.data = exec.dest_value;

  lc3b_ex_regfile #(
    .DEPTH (REG_COUNT)
  ) u_regfile (
    .clk      (clk),
    .rst      (rst),
    .rd_en    (in_accept),
    .rd_addr1 (in_data.instruction[8:6]),
    .rd_addr2 (in_data.instruction[2:0]),
    .wr       (rf_wr),
    .rd_data1 (sr1_value),
    .rd_data2 (sr2_value)
  );

  lc3b_ex_alu u_alu (
    .instruction (s1_item.instruction),
    .trap_target (s1_item.trap_target),
    .pc          (pc),
    .flags       (flags),
    .sr1_value   (sr1_value),
    .sr2_value   (sr2_value),
    .result      (exec)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      pc        <= 16'h0000;
      flags     <= lc3b_ex_pkg::FLAGS_RESET;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
        pc        <= exec.next_pc;
        flags     <= {exec.flag_n, exec.flag_z, exec.flag_p};
      end else begin
        if (out_ready) begin
          out_valid <= 1'b0;
        end
        if (cfg_valid && cfg_ready) begin
          pc <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item <= in_data;
    end
    if (s1_adv) begin
      out_data <= exec;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lc3b_ex_regfile.sv
// Register file of the LC-3b execute unit: a synchronous two-read, one-write memory.
// Depends on lc3b_ex_pkg for the write port struct.
`default_nettype none

module lc3b_ex_regfile #(
  parameter int DEPTH = 8
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          rd_en,
  input  wire logic [lc3b_ex_pkg::REG_AW-1:0] rd_addr1,
  input  wire logic [lc3b_ex_pkg::REG_AW-1:0] rd_addr2,
  input  wire lc3b_ex_pkg::rf_wr_t           wr,
  output logic [15:0]                        rd_data1,
  output logic [15:0]                        rd_data2
);

  localparam int AW = $clog2(DEPTH);

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] valid;

  logic [15:0]   q1;
  logic [15:0]   q2;
  logic          v1;
  logic          v2;
  logic [AW-1:0] ra1;
  logic [AW-1:0] ra2;

  // Most recent write, forwarded to a read that was issued on the same edge.
  logic          lw_en;
  logic [AW-1:0] lw_addr;
  logic [15:0]   lw_data;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr[AW-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      q1  <= mem[rd_addr1[AW-1:0]];
      q2  <= mem[rd_addr2[AW-1:0]];
      ra1 <= rd_addr1[AW-1:0];
      ra2 <= rd_addr2[AW-1:0];
    end
    if (wr.en) begin
      lw_addr <= wr.addr[AW-1:0];
      lw_data <= wr.data;
    end
  end

  // An entry that was never written reads as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      v1    <= 1'b0;
      v2    <= 1'b0;
      lw_en <= 1'b0;
    end else begin
      if (rd_en) begin
        v1 <= valid[rd_addr1[AW-1:0]];
        v2 <= valid[rd_addr2[AW-1:0]];
      end
      if (wr.en) begin
        valid[wr.addr[AW-1:0]] <= 1'b1;
        lw_en                  <= 1'b1;
      end
    end
  end

  always_comb begin
    if (lw_en && (lw_addr == ra1)) begin
      rd_data1 = lw_data;
    end else begin
      rd_data1 = v1 ? q1 : 16'h0000;
    end
    if (lw_en && (lw_addr == ra2)) begin
      rd_data2 = lw_data;
    end else begin
      rd_data2 = v2 ? q2 : 16'h0000;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/lc3b_ex_alu.sv
// Execute logic of the LC-3b unit: decodes one instruction and computes its result beat.
// Depends on lc3b_ex_pkg for opcodes, status codes and the result struct.
`default_nettype none

module lc3b_ex_alu (
  input  wire logic [15:0]      instruction,
  input  wire logic [15:0]      trap_target,
  input  wire logic [15:0]      pc,
  input  wire logic [2:0]       flags,
  input  wire logic [15:0]      sr1_value,
  input  wire logic [15:0]      sr2_value,
  output lc3b_ex_pkg::out_t     result
);

  logic [3:0]  opcode;
  logic [15:0] pc_inc;
  logic [15:0] imm5;
  logic [15:0] operand_b;
  logic [15:0] off9;
  logic [15:0] off11;
  logic [15:0] alu_value;
  logic [2:0]  flags_next;
  logic [15:0] npc;

  assign opcode    = instruction[15:12];
  assign pc_inc    = pc + 16'd2;
  assign imm5      = {{11{instruction[4]}}, instruction[4:0]};
  assign operand_b = instruction[5] ? imm5 : sr2_value;
  assign off9      = {{6{instruction[8]}}, instruction[8:0], 1'b0};
  assign off11     = {{4{instruction[10]}}, instruction[10:0], 1'b0};

  always_comb begin
    case (opcode)
      lc3b_ex_pkg::OP_ADD: alu_value = sr1_value + operand_b;
      lc3b_ex_pkg::OP_AND: alu_value = sr1_value & operand_b;
      default:             alu_value = sr1_value ^ operand_b;
    endcase
  end

  always_comb begin
    npc                 = pc_inc;
    flags_next          = flags;
    result.dest_written = 1'b0;
    result.dest_reg     = '0;
    result.dest_value   = 16'h0000;
    result.status       = lc3b_ex_pkg::ST_EXECUTED;
    case (opcode)
      lc3b_ex_pkg::OP_ADD, lc3b_ex_pkg::OP_AND, lc3b_ex_pkg::OP_XOR: begin
        result.dest_written = 1'b1;
        result.dest_reg     = instruction[11:9];
        result.dest_value   = alu_value;
        flags_next          = lc3b_ex_pkg::nzp_of(alu_value);
      end
      lc3b_ex_pkg::OP_BR: begin
        if (|(instruction[11:9] & flags)) begin
          npc = pc_inc + off9;
        end
      end
      lc3b_ex_pkg::OP_LEA: begin
        result.dest_written = 1'b1;
        result.dest_reg     = instruction[11:9];
        result.dest_value   = pc_inc + off9;
      end
      lc3b_ex_pkg::OP_JMP: begin
        npc = sr1_value;
      end
      lc3b_ex_pkg::OP_JSR: begin
        npc                 = instruction[11] ? (pc_inc + off11) : sr1_value;
        result.dest_written = 1'b1;
        result.dest_reg     = lc3b_ex_pkg::LINK_REG;
        result.dest_value   = pc_inc;
      end
      lc3b_ex_pkg::OP_TRAP: begin
        npc                 = trap_target;
        result.dest_written = 1'b1;
        result.dest_reg     = lc3b_ex_pkg::LINK_REG;
        result.dest_value   = pc_inc;
      end
      lc3b_ex_pkg::OP_LDB, lc3b_ex_pkg::OP_STB, lc3b_ex_pkg::OP_LDW,
      lc3b_ex_pkg::OP_STW, lc3b_ex_pkg::OP_RTI, lc3b_ex_pkg::OP_SHF: begin
        result.status = lc3b_ex_pkg::ST_UNIMPL;
      end
      default: begin
        result.status = lc3b_ex_pkg::ST_UNKNOWN;
      end
    endcase
    result.next_pc = npc;
    result.flag_n  = flags_next[2];
    result.flag_z  = flags_next[1];
    result.flag_p  = flags_next[0];
    result.halted  = (npc == 16'h0000);
  end

endmodule

`default_nettype wire

// File: rtl/core/lc3b_ex_checker.sv
// Port-level checker for the LC-3b execute unit, bound to the top level.
// Depends on lc3b_ex_pkg and the assertion macros header.
`default_nettype none
`include "lc3b_instruction_execute_macros.svh"

module lc3b_ex_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_ready,
  input wire lc3b_ex_pkg::out_t out_data
);

  // A stalled result beat holds its value.
  `LC3B_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result beat changed while stalled")

  // Halted reports exactly a zero next PC.
  `LC3B_ASSERT_COND(a_halted, !out_valid || (out_data.halted == (out_data.next_pc == 16'h0000)), "halted does not match next_pc")

  // The condition flags always name exactly one of N, Z and P.
  `LC3B_ASSERT_COND(a_flags_onehot, !out_valid || $onehot({out_data.flag_n, out_data.flag_z, out_data.flag_p}), "condition flags not one-hot")

  // A beat that writes no register carries a zero index and value, and skipped opcodes write nothing.
  `LC3B_ASSERT_COND(a_no_write_zero, !out_valid || out_data.dest_written || ((out_data.dest_reg == 3'd0) && (out_data.dest_value == 16'h0000)), "idle destination fields not zero")

  `LC3B_ASSERT_COND(a_skip_no_write, !out_valid || (out_data.status == lc3b_ex_pkg::ST_EXECUTED) || !out_data.dest_written, "flagged opcode wrote a register")

endmodule

bind lc3b_instruction_execute lc3b_ex_checker u_checker (.*);

`default_nettype wire

// File: tb/sv/tb_lc3b_instruction_execute.sv
// Self-checking testbench for the LC-3b execute unit: drives instruction beats, predicts
// every result beat from its own architectural copy of PC, registers and flags.
// Depends on lc3b_ex_pkg and lc3b_instruction_execute.
`timescale 1ns / 1ps

module tb_lc3b_instruction_execute;

  // Opcodes that the package leaves unnamed; both are reserved in LC-3b.
  localparam logic [3:0] OP_RSV10 = 4'd10;
  localparam logic [3:0] OP_RSV11 = 4'd11;
  localparam int MAX_GAP = 14;
  localparam int SETTLE = 8;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid;
  logic              in_ready;
  lc3b_ex_pkg::in_t  in_data;
  logic              out_valid;
  logic              out_ready;
  lc3b_ex_pkg::out_t out_data;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [15:0]       cfg_data;

  // Architectural state as the predictor sees it.
  logic [15:0] arch_pc;
  logic [15:0] arch_regs [8];
  logic [2:0]  arch_flags;

  lc3b_ex_pkg::out_t pending_results[$];
  int   errors = 0;
  bit   tx_no_gaps = 1'b0;
  bit   rx_no_gaps = 1'b0;
  int   hold_len = 0;

  always #1 clk = ~clk;

  lc3b_instruction_execute #(.REG_COUNT(8)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  function automatic lc3b_ex_pkg::out_t execute_insn(input logic [15:0] ir,
                                                     input logic [15:0] vector);
    logic [3:0]  op;
    logic [15:0] seq_pc;
    logic [15:0] target;
    logic [15:0] br_off;
    logic [15:0] jsr_off;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] res;
    lc3b_ex_pkg::out_t r;
    op      = ir[15:12];
    seq_pc  = arch_pc + 16'd2;
    br_off  = {{6{ir[8]}}, ir[8:0], 1'b0};
    jsr_off = {{4{ir[10]}}, ir[10:0], 1'b0};
    target  = seq_pc;
    r       = '0;
    r.status = lc3b_ex_pkg::ST_EXECUTED;
    case (op)
      lc3b_ex_pkg::OP_ADD, lc3b_ex_pkg::OP_AND, lc3b_ex_pkg::OP_XOR: begin
        a = arch_regs[ir[8:6]];
        b = ir[5] ? {{11{ir[4]}}, ir[4:0]} : arch_regs[ir[2:0]];
        if (op == lc3b_ex_pkg::OP_ADD) begin
          res = a + b;
        end else if (op == lc3b_ex_pkg::OP_AND) begin
          res = a & b;
        end else begin
          res = a ^ b;
        end
        r.dest_written = 1'b1;
        r.dest_reg     = ir[11:9];
        r.dest_value   = res;
        arch_flags     = (res == 16'h0000) ? 3'b010 : {res[15], 1'b0, ~res[15]};
      end
      lc3b_ex_pkg::OP_BR: begin
        if ((ir[11:9] & arch_flags) != 3'b000) begin
          target = seq_pc + br_off;
        end
      end
      lc3b_ex_pkg::OP_LEA: begin
        r.dest_written = 1'b1;
        r.dest_reg     = ir[11:9];
        r.dest_value   = seq_pc + br_off;
      end
      lc3b_ex_pkg::OP_JMP: begin
        target = arch_regs[ir[8:6]];
      end
      lc3b_ex_pkg::OP_JSR: begin
        // The base register is read before the link write lands.
        target         = ir[11] ? seq_pc + jsr_off : arch_regs[ir[8:6]];
        r.dest_written = 1'b1;
        r.dest_reg     = lc3b_ex_pkg::LINK_REG;
        r.dest_value   = seq_pc;
      end
      lc3b_ex_pkg::OP_TRAP: begin
        target         = vector;
        r.dest_written = 1'b1;
        r.dest_reg     = lc3b_ex_pkg::LINK_REG;
        r.dest_value   = seq_pc;
      end
      lc3b_ex_pkg::OP_LDB, lc3b_ex_pkg::OP_STB, lc3b_ex_pkg::OP_LDW,
      lc3b_ex_pkg::OP_STW, lc3b_ex_pkg::OP_RTI, lc3b_ex_pkg::OP_SHF: begin
        r.status = lc3b_ex_pkg::ST_UNIMPL;
      end
      default: begin
        r.status = lc3b_ex_pkg::ST_UNKNOWN;
      end
    endcase
    if (r.dest_written) begin
      arch_regs[r.dest_reg] = r.dest_value;
    end
    arch_pc = target;
    r.next_pc = target;
    {r.flag_n, r.flag_z, r.flag_p} = arch_flags;
    r.halted = (target == 16'h0000);
    return r;
  endfunction

  function automatic logic [15:0] rand_insn();
    logic [3:0]  unimpl_ops [6];
    logic [3:0]  op;
    logic [15:0] w;
    int          pick;
    unimpl_ops = '{lc3b_ex_pkg::OP_LDB, lc3b_ex_pkg::OP_STB, lc3b_ex_pkg::OP_LDW,
                   lc3b_ex_pkg::OP_STW, lc3b_ex_pkg::OP_RTI, lc3b_ex_pkg::OP_SHF};
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      op = lc3b_ex_pkg::OP_ADD;
    end else if (pick < 27) begin
      op = lc3b_ex_pkg::OP_AND;
    end else if (pick < 39) begin
      op = lc3b_ex_pkg::OP_XOR;
    end else if (pick < 54) begin
      op = lc3b_ex_pkg::OP_BR;
    end else if (pick < 62) begin
      op = lc3b_ex_pkg::OP_LEA;
    end else if (pick < 69) begin
      op = lc3b_ex_pkg::OP_JMP;
    end else if (pick < 79) begin
      op = lc3b_ex_pkg::OP_JSR;
    end else if (pick < 87) begin
      op = lc3b_ex_pkg::OP_TRAP;
    end else if (pick < 95) begin
      op = unimpl_ops[$urandom_range(0, 5)];
    end else begin
      op = $urandom_range(0, 1) ? OP_RSV10 : OP_RSV11;
    end
    w = 16'($urandom);
    w[15:12] = op;
    return w;
  endfunction

  // A zero vector now and then sends TRAP to address 0, which reports halted.
  function automatic logic [15:0] rand_vector();
    logic [15:0] w;
    w = 16'($urandom);
    return ($urandom_range(0, 7) == 0) ? 16'h0000 : w;
  endfunction

  // Entered and left right after a rising edge; valid stays high when the next beat
  // follows without a gap.
  task automatic issue(input logic [15:0] ir, input logic [15:0] vector);
    int  gap;
    lc3b_ex_pkg::in_t x;
    gap = tx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
    x.instruction = ir;
    x.trap_target = vector;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= x;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(execute_insn(ir, vector));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_start(input logic [15:0] addr);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= addr;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    arch_pc = addr;
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin : result_check
    lc3b_ex_pkg::out_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with none expected, got %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("next_pc", want.next_pc, out_data.next_pc);
        check_field("dest_written", 16'(want.dest_written), 16'(out_data.dest_written));
        check_field("dest_reg", 16'(want.dest_reg), 16'(out_data.dest_reg));
        check_field("dest_value", want.dest_value, out_data.dest_value);
        check_field("flag_n", 16'(want.flag_n), 16'(out_data.flag_n));
        check_field("flag_z", 16'(want.flag_z), 16'(out_data.flag_z));
        check_field("flag_p", 16'(want.flag_p), 16'(out_data.flag_p));
        check_field("status", 16'(want.status), 16'(out_data.status));
        check_field("halted", 16'(want.halted), 16'(out_data.halted));
      end
    end
  end

  // Result side: a random stall before each beat, or a long hold-off when one is asked.
  initial begin : result_ready
    int n;
    out_ready <= 1'b0;
    wait (!rst);
    @(posedge clk);
    forever begin
      n = rx_no_gaps ? 0 : $urandom_range(0, MAX_GAP);
      if (hold_len > 0) begin
        n = hold_len;
        hold_len = 0;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  task automatic test_directed_ops();
    logic [3:0] odd_ops [8];
    odd_ops = '{lc3b_ex_pkg::OP_LDB, lc3b_ex_pkg::OP_STB, lc3b_ex_pkg::OP_LDW,
                lc3b_ex_pkg::OP_STW, lc3b_ex_pkg::OP_RTI, lc3b_ex_pkg::OP_SHF,
                OP_RSV10, OP_RSV11};
    issue(16'h01FF, 16'hFFFF);  // BR with no condition bits is a no-op
    issue(16'h1230, 16'h0000);  // ADD R1, R0, #-16
    issue(16'h142F, 16'hFFFF);  // ADD R2, R0, #15
    issue(16'h1642, 16'h0000);  // ADD R3, R1, R2
    issue(16'h58E0, 16'hFFFF);  // AND R4, R3, #0
    issue(16'h5AC1, 16'h0000);  // AND R5, R3, R1
    issue(16'h9C7F, 16'hFFFF);  // XOR R6, R1, #-1
    issue(16'h90C3, 16'h0000);  // XOR R0, R3, R3
    issue(16'h04FF, 16'hFFFF);  // BRz +255, taken
    issue(16'h0F00, 16'h0000);  // BRnzp -256
    issue(16'h0300, 16'hFFFF);  // BRp with Z set, not taken
    issue(16'hEEFF, 16'h0000);  // LEA R7, +255
    issue(16'hE100, 16'hFFFF);  // LEA R0, -256
    issue(16'hC1C0, 16'h0000);  // JMP R7
    issue(16'h4BFF, 16'hFFFF);  // JSR +1023
    issue(16'h4C00, 16'h0000);  // JSR -1024
    issue(16'h41C0, 16'hFFFF);  // JSRR R7 uses R7 from before the link
    issue(16'hF025, 16'h0000);  // TRAP to address 0 reports halted
    issue(16'hF0FF, 16'hFFFF);
    foreach (odd_ops[i]) begin
      issue({odd_ops[i], 12'(i * 16'h0555)}, rand_vector());
    end
  endtask

  task automatic test_pc_wrap();
    set_start(16'hFFFE);
    issue(16'h0000, 16'h1234);
    set_start(16'hFFFF);
    issue(16'h1020, 16'h1234);
    issue(16'hA000, 16'h1234);
  endtask

  task automatic test_random_program(input int count);
    repeat (count) issue(rand_insn(), rand_vector());
  endtask

  // The receiver stops for a long stretch while beats keep coming back to back.
  task automatic test_back_pressure();
    tx_no_gaps = 1'b1;
    hold_len = 400;
    test_random_program(150);
    tx_no_gaps = 1'b0;
  endtask

  task automatic test_no_idle(input int count);
    tx_no_gaps = 1'b1;
    rx_no_gaps = 1'b1;
    test_random_program(count);
    tx_no_gaps = 1'b0;
    rx_no_gaps = 1'b0;
  endtask

  initial begin : main
    logic [15:0] addr;
    in_valid  <= 1'b0;
    in_data   <= '0;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    arch_pc    = 16'h0000;
    arch_flags = lc3b_ex_pkg::FLAGS_RESET;
    foreach (arch_regs[i]) arch_regs[i] = 16'h0000;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_directed_ops();
    test_pc_wrap();
    set_start(16'h3000);
    test_random_program(500);
    set_start(16'hFFFF);
    test_random_program(400);
    test_back_pressure();
    set_start(16'h0000);
    test_no_idle(200);
    addr = 16'($urandom);
    set_start(addr);
    test_random_program(500);

    drain_results();
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin : watchdog
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
